### hw/rtl/bdpe_pkg.sv
// Shared types, constants and register codes of the button debounce unit.
package bdpe_pkg;

  // Default number of switches served by one unit.
  localparam int unsigned SWITCH_NUM_DEF = 4;

  // Field widths.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned LONG_W     = 16;
  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [LONG_W-1:0]     LONG_PRESS_RST = 16'd3000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 8'd25;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd1;

  // Request types.
  localparam logic REQ_STATUS = 1'b0;
  localparam logic REQ_EVENT  = 1'b1;

  // Press events reported with each result.
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  // Configuration register contents.
  typedef struct packed {
    logic [LONG_W-1:0]     long_press_ms;
    logic [DEBOUNCE_W-1:0] settle_ms;
  } cfg_t;

  // One poll of one switch.
  typedef struct packed {
    logic               req_type;
    logic [INDEX_W-1:0] switch_index;
    logic               raw_level;
    logic [TIME_W-1:0]  now_ms;
  } poll_t;

  // One result.
  typedef struct packed {
    logic   pressed;
    event_t event_res;
  } res_t;

endpackage

### hw/rtl/button_debounce_press_events_unit.sv
// An accepted poll passes through the poll register and then the result register.
// Throughput: one poll per cycle while in_stall is low; the per-switch state is read and written in the same cycle
// between the poll register and the result register, so back-to-back polls see fresh state.
// A poll is taken while a result waits, until both the poll and result registers are full.
// Reset clears all per-switch state to released/idle and loads the default registers.
// Top level of the button debounce and press event unit.
module button_debounce_press_events_unit #(
  parameter int unsigned SWITCH_NUM = bdpe_pkg::SWITCH_NUM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [bdpe_pkg::INDEX_W-1:0]     switch_index,
  input  logic                             raw_level,
  input  logic [bdpe_pkg::TIME_W-1:0]      now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             pressed,
  output logic [1:0]                       event_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bdpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bdpe_pkg::cfg_t  cfg;
  bdpe_pkg::poll_t poll;
  bdpe_pkg::res_t  res_comb;
  bdpe_pkg::res_t  res;
  logic            poll_valid;
  logic            advance;

  bdpe_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register moves unless it holds a stalled result.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = poll_valid && !advance;

  // Poll register.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (!in_stall) begin
      poll_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      poll.req_type     <= req_type;
      poll.switch_index <= switch_index;
      poll.raw_level    <= raw_level;
      poll.now_ms       <= now_ms;
    end
  end

  bdpe_core #(
    .SWITCH_NUM (SWITCH_NUM)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .commit (poll_valid && advance),
    .poll   (poll),
    .cfg    (cfg),
    .res    (res_comb)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign pressed   = res.pressed;
  assign event_res = res.event_res;

endmodule

### hw/rtl/bdpe_cfg_regs.sv
// Configuration registers of the button debounce unit.
module bdpe_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bdpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdpe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bdpe_pkg::cfg_t                   cfg
);

  logic [bdpe_pkg::LONG_W-1:0]     long_press_ms;
  logic [bdpe_pkg::DEBOUNCE_W-1:0] settle_ms;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= bdpe_pkg::LONG_PRESS_RST;
      settle_ms     <= bdpe_pkg::DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bdpe_pkg::CFG_LONG_PRESS: long_press_ms <= cfg_data[bdpe_pkg::LONG_W-1:0];
        bdpe_pkg::CFG_DEBOUNCE:   settle_ms     <= cfg_data[bdpe_pkg::DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.long_press_ms = long_press_ms;
  assign cfg.settle_ms     = settle_ms;

endmodule

### hw/rtl/bdpe_core.sv
// Per-switch debounce and press tracking state with its update logic.
module bdpe_core #(
  parameter int unsigned SWITCH_NUM = bdpe_pkg::SWITCH_NUM_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            commit,
  input  bdpe_pkg::poll_t poll,
  input  bdpe_pkg::cfg_t  cfg,
  output bdpe_pkg::res_t  res
);

  localparam int unsigned IDX_W = (SWITCH_NUM > 1) ? $clog2(SWITCH_NUM) : 1;
  localparam int unsigned TW    = bdpe_pkg::TIME_W;

  logic          stable_level     [SWITCH_NUM];
  logic          previous_raw     [SWITCH_NUM];
  logic [TW-1:0] last_change_time [SWITCH_NUM];
  logic [TW-1:0] press_start_time [SWITCH_NUM];
  logic          press_active     [SWITCH_NUM];
  logic          long_done        [SWITCH_NUM];

  logic [IDX_W-1:0] k;
  logic             in_range;
  logic             changed;
  logic [TW-1:0]    change_time_next;
  logic [TW-1:0]    settle_age;
  logic             stable_next;
  logic             held;
  logic             active_next;
  logic [TW-1:0]    start_next;
  logic             long_cur;
  logic             long_next;
  logic [TW-1:0]    hold_age;
  bdpe_pkg::event_t ev;

  assign k        = poll.switch_index[IDX_W-1:0];
  assign in_range = poll.switch_index < bdpe_pkg::INDEX_W'(SWITCH_NUM);

  // Debounce: a raw change restarts the timer; a settled level becomes stable.
  always_comb begin
    changed          = poll.raw_level != previous_raw[k];
    change_time_next = changed ? poll.now_ms : last_change_time[k];
    settle_age       = poll.now_ms - change_time_next;
    stable_next      = (settle_age >= {{(TW - bdpe_pkg::DEBOUNCE_W){1'b0}}, cfg.settle_ms})
                       ? poll.raw_level : stable_level[k];
    held             = ~stable_next;
  end

  // Press tracking for event polls.
  always_comb begin
    active_next = press_active[k];
    start_next  = press_start_time[k];
    long_cur    = press_active[k] ? long_done[k] : 1'b0;
    long_next   = long_done[k];
    hold_age    = '0;
    ev          = bdpe_pkg::EV_NONE;
    if (poll.req_type == bdpe_pkg::REQ_EVENT) begin
      if (held) begin
        active_next = 1'b1;
        start_next  = press_active[k] ? press_start_time[k] : poll.now_ms;
        hold_age    = poll.now_ms - start_next;
        long_next   = long_cur;
        if (!long_cur &&
            hold_age >= {{(TW - bdpe_pkg::LONG_W){1'b0}}, cfg.long_press_ms}) begin
          long_next = 1'b1;
          ev        = bdpe_pkg::EV_LONG;
        end
      end else if (press_active[k]) begin
        ev          = long_done[k] ? bdpe_pkg::EV_NONE : bdpe_pkg::EV_SHORT;
        active_next = 1'b0;
        start_next  = '0;
        long_next   = 1'b0;
      end
    end
  end

  // Out-of-range switches report released with no event.
  assign res.pressed   = in_range & held;
  assign res.event_res = in_range ? ev : bdpe_pkg::EV_NONE;

  // State update when the poll is committed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SWITCH_NUM; i++) begin
        stable_level[i]     <= 1'b1;
        previous_raw[i]     <= 1'b1;
        last_change_time[i] <= '0;
        press_start_time[i] <= '0;
        press_active[i]     <= 1'b0;
        long_done[i]        <= 1'b0;
      end
    end else if (commit && in_range) begin
      stable_level[k]     <= stable_next;
      previous_raw[k]     <= poll.raw_level;
      last_change_time[k] <= change_time_next;
      press_start_time[k] <= start_next;
      press_active[k]     <= active_next;
      long_done[k]        <= long_next;
    end
  end

endmodule

### hw/rtl/bdpe_checker.sv
// Port-level checker for the button debounce unit and its bind statement.
module bdpe_checker #(
  parameter int unsigned SWITCH_NUM = bdpe_pkg::SWITCH_NUM_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             req_type,
  input logic [bdpe_pkg::INDEX_W-1:0]     switch_index,
  input logic                             raw_level,
  input logic [bdpe_pkg::TIME_W-1:0]      now_ms,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             pressed,
  input logic [1:0]                       event_res,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [bdpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [bdpe_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pressed) && $stable(event_res))
    else $error("result changed while stalled");

  // Input is only held off while a result is blocked downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // A status poll never reports an event.
  a_status_no_event: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == bdpe_pkg::REQ_STATUS) ##1
    (!out_valid || !out_stall) |=> out_valid && event_res == bdpe_pkg::EV_NONE)
    else $error("status poll reported an event");

  // An unknown switch reports released with no event.
  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && switch_index >= bdpe_pkg::INDEX_W'(SWITCH_NUM)) ##1
    (!out_valid || !out_stall) |=> out_valid && !pressed &&
    event_res == bdpe_pkg::EV_NONE)
    else $error("unknown switch gave a non-empty result");

endmodule

bind button_debounce_press_events_unit bdpe_checker #(
  .SWITCH_NUM (SWITCH_NUM)
) u_bdpe_checker (.*);
